/* hdl/ramr_pkg.sv */
// ramr_pkg: shared types and constants for the rational add/multiply/reduce block
// used by the interfaces, the divider, the top level and the checker; no dependencies
`default_nettype none

package ramr_pkg;

  // field widths
  localparam int unsigned IN_W   = 16;
  localparam int unsigned NUM_W  = 33;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned PROD_W = 2 * IN_W;
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned SHIFT_W   = 5;

  // action codes
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_MUL = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hdl/ramr_if.sv */
// ramr_in_if and ramr_out_if: valid/ready channels for operand and result beats
// depends on ramr_pkg for the field widths
`default_nettype none

interface ramr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [ramr_pkg::IN_W-1:0]     first_num;
  logic signed [ramr_pkg::IN_W-1:0]     first_den;
  logic signed [ramr_pkg::IN_W-1:0]     second_num;
  logic signed [ramr_pkg::IN_W-1:0]     second_den;

  modport source (output valid, action, first_num, first_den, second_num, second_den,
                  input ready);
  modport sink   (input valid, action, first_num, first_den, second_num, second_den,
                  output ready);
  modport mon    (input valid, ready, action, first_num, first_den, second_num,
                  second_den);
endinterface

interface ramr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ramr_pkg::NUM_W-1:0]    result_num;
  logic        [ramr_pkg::DEN_W-1:0]    result_den;
  logic                                 is_zero;
  logic                                 status;

  modport source (output valid, result_num, result_den, is_zero, status, input ready);
  modport sink   (input valid, result_num, result_den, is_zero, status, output ready);
  modport mon    (input valid, ready, result_num, result_den, is_zero, status);
endinterface

`default_nettype wire

/* hdl/rational_add_multiply_reduce.sv */
// Sequence from an accepted beat to its result beat: multiplier steps, binary-GCD steps and
// the divider launch, two divisions by the GCD at one quotient bit per cycle, then the output
// register; a zero-denominator beat goes from the multiplier state straight to the output.
// Throughput: one item at a time; the next beat waits until the result is registered, so a result stall holds it off.
// Reset: rst_n is synchronous, active low; it clears the sequencer and the output valid.
// rational_add_multiply_reduce: top level; depends on ramr_pkg, ramr_if, ramr_div
`default_nettype none

module rational_add_multiply_reduce (
  input  logic       clk,
  input  logic       rst_n,
  ramr_in_if.sink    in_bus,
  ramr_out_if.source out_bus
);
  import ramr_pkg::*;

  state_t state_r, state_nxt;

  // latched operands
  logic                    act_r, act_nxt;
  logic                    err_r, err_nxt;
  logic signed [IN_W-1:0]  n1_r, n1_nxt, d1_r, d1_nxt, n2_r, n2_nxt, d2_r, d2_nxt;

  // product / sum stage
  logic [1:0]              step_r, step_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [NUM_W-1:0] acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;

  // magnitudes and gcd
  logic [DIV_W-1:0]        un_r, un_nxt;
  logic [DEN_W-1:0]        ud_r, ud_nxt;
  logic [DIV_W-1:0]        ga_r, ga_nxt, gb_r, gb_nxt;
  logic [SHIFT_W-1:0]      k_r, k_nxt;
  logic [DIV_W-1:0]        g_r, g_nxt;
  logic [DIV_W-1:0]        qn_r, qn_nxt;
  logic [DEN_W-1:0]        qd_r, qd_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [NUM_W-1:0] out_num_r, out_num_nxt;
  logic [DEN_W-1:0]        out_den_r, out_den_nxt;
  logic                    out_zero_r, out_zero_nxt;
  logic                    out_status_r, out_status_nxt;

  // shared units
  logic signed [IN_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [DIV_W:0]           gdiff;
  logic [DIV_W:0]           gdiff_neg;
  logic [DIV_W-1:0]         gval;
  logic signed [NUM_W-1:0]  acc_neg;
  logic signed [PROD_W-1:0] prod_neg;
  logic [NUM_W-1:0]         qn_ext;
  logic                     in_acc, out_free, gcd_end;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  ramr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign gcd_end  = (ga_r == '0);

  // multiplier operand select
  always_comb begin
    case (step_r)
      2'd0:    begin mul_a = n1_r; mul_b = (act_r == ACT_MUL) ? n2_r : d2_r; end
      2'd1:    begin mul_a = d1_r; mul_b = n2_r; end
      default: begin mul_a = d1_r; mul_b = d2_r; end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // magnitude, gcd and sign helpers
  assign acc_neg   = -acc_r;
  assign prod_neg  = -prod_r;
  assign gdiff     = {1'b0, ga_r} - {1'b0, gb_r};
  assign gdiff_neg = -gdiff;
  assign gval      = gb_r << k_r;
  assign qn_ext    = {1'b0, qn_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL: begin
        if (err_r) state_nxt = ST_OUT;
        else if (step_r == 2'd3) state_nxt = ST_GCD;
      end
      ST_GCD:  if (gcd_end) state_nxt = ST_DIVN;
      ST_DIVN: if (div_rsp.done) state_nxt = ST_DIVD;
      ST_DIVD: if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_nxt = act_r;  err_nxt = err_r;
    n1_nxt = n1_r;  d1_nxt = d1_r;  n2_nxt = n2_r;  d2_nxt = d2_r;
    step_nxt = step_r;  prod_nxt = prod_r;  acc_nxt = acc_r;  neg_nxt = neg_r;
    un_nxt = un_r;  ud_nxt = ud_r;  ga_nxt = ga_r;  gb_nxt = gb_r;  k_nxt = k_r;
    g_nxt = g_r;  qn_nxt = qn_r;  qd_nxt = qd_r;
    out_valid_nxt = out_valid_r;  out_num_nxt = out_num_r;  out_den_nxt = out_den_r;
    out_zero_nxt = out_zero_r;  out_status_nxt = out_status_r;
    div_req.start    = 1'b0;
    div_req.dividend = un_r;
    div_req.divisor  = g_r;

    if (out_valid_r && out_bus.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_bus.action;
          n1_nxt   = in_bus.first_num;
          d1_nxt   = in_bus.first_den;
          n2_nxt   = in_bus.second_num;
          d2_nxt   = in_bus.second_den;
          err_nxt  = (in_bus.first_den == '0) || (in_bus.second_den == '0);
          step_nxt = 2'd0;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 2'd1;
        prod_nxt = mul_p;
        case (step_r)
          2'd0: ;
          2'd1: acc_nxt = {prod_r[PROD_W-1], prod_r};
          2'd2: if (act_r == ACT_ADD) acc_nxt = acc_r + {prod_r[PROD_W-1], prod_r};
          default: begin
            // raw result in acc_r over prod_r: split into sign and magnitudes
            prod_nxt = prod_r;
            neg_nxt  = acc_r[NUM_W-1] ^ prod_r[PROD_W-1];
            un_nxt   = acc_r[NUM_W-1] ? acc_neg[DIV_W-1:0] : acc_r[DIV_W-1:0];
            ud_nxt   = prod_r[PROD_W-1] ? prod_neg[DEN_W-1:0] : prod_r[DEN_W-1:0];
            ga_nxt   = acc_r[NUM_W-1] ? acc_neg[DIV_W-1:0] : acc_r[DIV_W-1:0];
            gb_nxt   = {1'b0, (prod_r[PROD_W-1] ? prod_neg[DEN_W-1:0] : prod_r[DEN_W-1:0])};
            k_nxt    = '0;
          end
        endcase
      end
      ST_GCD: begin
        // binary gcd, one step per cycle
        if (gcd_end) begin
          g_nxt            = gval;
          div_req.start    = 1'b1;
          div_req.dividend = un_r;
          div_req.divisor  = gval;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          k_nxt  = k_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (!gdiff[DIV_W]) begin
          ga_nxt = gdiff[DIV_W:1];
        end else begin
          gb_nxt = gdiff_neg[DIV_W:1];
        end
      end
      ST_DIVN: begin
        if (div_rsp.done) begin
          qn_nxt           = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = {1'b0, ud_r};
          div_req.divisor  = g_r;
        end
      end
      ST_DIVD: begin
        if (div_rsp.done) qd_nxt = div_rsp.quotient[DEN_W-1:0];
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_num_nxt    = '0;
            out_den_nxt    = '0;
            out_zero_nxt   = 1'b0;
            out_status_nxt = STATUS_ZERO_DEN;
          end else begin
            out_num_nxt    = neg_r ? -qn_ext : qn_ext;
            out_den_nxt    = qd_r;
            out_zero_nxt   = (qn_r == '0);
            out_status_nxt = STATUS_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt;  err_r <= err_nxt;
    n1_r <= n1_nxt;  d1_r <= d1_nxt;  n2_r <= n2_nxt;  d2_r <= d2_nxt;
    prod_r <= prod_nxt;  acc_r <= acc_nxt;  neg_r <= neg_nxt;
    un_r <= un_nxt;  ud_r <= ud_nxt;  ga_r <= ga_nxt;  gb_r <= gb_nxt;  k_r <= k_nxt;
    g_r <= g_nxt;  qn_r <= qn_nxt;  qd_r <= qd_nxt;
    out_num_r <= out_num_nxt;  out_den_r <= out_den_nxt;
    out_zero_r <= out_zero_nxt;  out_status_r <= out_status_nxt;
  end

  assign in_bus.ready       = (state_r == ST_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.result_num = out_num_r;
  assign out_bus.result_den = out_den_r;
  assign out_bus.is_zero    = out_zero_r;
  assign out_bus.status     = out_status_r;

endmodule

`default_nettype wire

/* hdl/ramr_div.sv */
// ramr_div: restoring unsigned divider, one quotient bit per cycle
// depends on ramr_pkg for div_req_t, div_rsp_t and DIV_W
`default_nettype none

module ramr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ramr_pkg::div_req_t req,
  output ramr_pkg::div_rsp_t rsp
);
  import ramr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;

  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;
  logic                 take;

  // one shift-subtract step
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign take    = ~trial[DIV_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = take ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

/* hdl/ramr_chk.sv */
// ramr_chk: port-level checks for rational_add_multiply_reduce, plus its bind
// depends on ramr_pkg and the ramr_in_if / ramr_out_if interfaces
`default_nettype none

module ramr_chk (
  input logic         clk,
  input logic         rst_n,
  ramr_in_if.sink     in_bus,
  ramr_out_if.source  out_bus
);
  import ramr_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |=> out_bus.valid && $stable(out_bus.result_num)
      && $stable(out_bus.result_den) && $stable(out_bus.status))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> !in_bus.ready)
    else $error("operand beat accepted while busy");

  // error results carry zeros
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == STATUS_ZERO_DEN |->
      out_bus.result_den == '0 && out_bus.result_num == '0 && !out_bus.is_zero)
    else $error("error result with nonzero fields");

  // good results have a positive denominator
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == STATUS_OK |-> out_bus.result_den != '0)
    else $error("zero denominator on good result");

  // zero flag tracks the numerator
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == STATUS_OK |->
      out_bus.is_zero == (out_bus.result_num == '0))
    else $error("zero flag does not match numerator");

endmodule

bind rational_add_multiply_reduce ramr_chk u_ramr_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_bus  (in_bus),
  .out_bus (out_bus)
);

`default_nettype wire

/* tb/sv/ramr_checker.sv */
// ramr_checker: watches the operand and result channels of the rational add/multiply/reduce
// block, predicts each reduced fraction and compares it field by field with the result beats
// depends on ramr_pkg for widths and codes, and on ramr_in_if / ramr_out_if

module ramr_checker (
  input  logic        clk,
  input  logic        rst_n,
  ramr_in_if.mon      in_mon,
  ramr_out_if.mon     out_mon,
  input  logic        flush,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ramr_pkg::*;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic        [DEN_W-1:0] den;
    logic                    is_zero;
    logic                    status;
  } reduced_t;

  reduced_t    expected_fractions[$];
  logic        flushed;
  int unsigned result_count;

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // cross products, sign moved to the numerator, euclid on magnitudes
  function automatic reduced_t reduce_operands(input logic act,
                                               input logic signed [IN_W-1:0] n1,
                                               input logic signed [IN_W-1:0] d1,
                                               input logic signed [IN_W-1:0] n2,
                                               input logic signed [IN_W-1:0] d2);
    longint          raw_num;
    longint          raw_den;
    longint unsigned mag_num;
    longint unsigned mag_den;
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    logic            neg;
    reduced_t        res;
    res = '0;
    // zero denominator: error, everything else cleared
    if (d1 == 0 || d2 == 0) begin
      res.status = STATUS_ZERO_DEN;
      return res;
    end
    if (act == ACT_ADD) begin
      raw_num = longint'(n1) * longint'(d2) + longint'(d1) * longint'(n2);
    end else begin
      raw_num = longint'(n1) * longint'(n2);
    end
    raw_den = longint'(d1) * longint'(d2);
    neg     = (raw_num < 0) != (raw_den < 0);
    mag_num = (raw_num < 0) ? longint'(-raw_num) : longint'(raw_num);
    mag_den = (raw_den < 0) ? longint'(-raw_den) : longint'(raw_den);
    // gcd(0, d) is d, so a zero numerator comes out as 0/1
    a = mag_num;
    b = mag_den;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    mag_num     = mag_num / a;
    mag_den     = mag_den / a;
    res.num     = NUM_W'(neg ? -longint'(mag_num) : longint'(mag_num));
    res.den     = DEN_W'(mag_den);
    res.is_zero = (mag_num == 0);
    res.status  = STATUS_OK;
    return res;
  endfunction

  // result beats are matched before operand beats are queued on the same edge
  always @(posedge clk) begin
    reduced_t want;
    reduced_t got;
    if (!rst_n) begin
      mismatches   = 0;
      pending      = 0;
      flushed      = 1'b0;
      result_count = 0;
      expected_fractions.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.num     = out_mon.result_num;
        got.den     = out_mon.result_den;
        got.is_zero = out_mon.is_zero;
        got.status  = out_mon.status;
        if (expected_fractions.size() == 0) begin
          report_mismatch($sformatf("result beat %0d (%0d/%0d) with nothing expected",
                                    result_count, got.num, got.den));
        end else begin
          want = expected_fractions.pop_front();
          if (got.num !== want.num)
            report_mismatch($sformatf("beat %0d result_num %0d, expected %0d",
                                      result_count, got.num, want.num));
          if (got.den !== want.den)
            report_mismatch($sformatf("beat %0d result_den %0d, expected %0d",
                                      result_count, got.den, want.den));
          if (got.is_zero !== want.is_zero)
            report_mismatch($sformatf("beat %0d is_zero %b, expected %b",
                                      result_count, got.is_zero, want.is_zero));
          if (got.status !== want.status)
            report_mismatch($sformatf("beat %0d status %b, expected %b",
                                      result_count, got.status, want.status));
        end
        result_count++;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_fractions.push_back(reduce_operands(in_mon.action, in_mon.first_num,
                                                     in_mon.first_den, in_mon.second_num,
                                                     in_mon.second_den));
      end
      // end of run: anything still queued never came out
      if (flush && !flushed) begin
        flushed = 1'b1;
        if (expected_fractions.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_fractions.size()));
          expected_fractions.delete();
        end
      end
      pending = expected_fractions.size();
    end
  end

endmodule

/* tb/sv/tb_rational_add_multiply_reduce.sv */
// tb_rational_add_multiply_reduce: clock, reset and operand/result stimulus for the rational
// add/multiply/reduce block; directed corners, then random beats over four idle/stall phases
// depends on ramr_pkg, ramr_if, the block itself and ramr_checker

module tb_rational_add_multiply_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  import ramr_pkg::*;

  localparam int unsigned PHASE_BEATS    = 270;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        flush;
  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned stuck_cycles;
  int unsigned add_beats;
  int unsigned mul_beats;
  int unsigned zero_den_beats;

  ramr_in_if  in_bus ();
  ramr_out_if out_bus ();

  rational_add_multiply_reduce u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  ramr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .flush      (flush),
    .mismatches (mismatch_count),
    .pending    (pending_results)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side backpressure, redrawn every falling edge
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, stuck_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // one operand beat, entered and left at a falling edge
  task automatic send_operands(input logic act,
                               input logic signed [IN_W-1:0] n1,
                               input logic signed [IN_W-1:0] d1,
                               input logic signed [IN_W-1:0] n2,
                               input logic signed [IN_W-1:0] d2);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_bus.action     = act;
    in_bus.first_num  = n1;
    in_bus.first_den  = d1;
    in_bus.second_num = n2;
    in_bus.second_den = d2;
    in_bus.valid      = 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    in_bus.valid = 1'b0;
    if (act == ACT_ADD) add_beats++;
    else mul_beats++;
    if (d1 == 0 || d2 == 0) zero_den_beats++;
  endtask

  // hold off until every queued result has come out
  task automatic wait_results_drained();
    while (pending_results != 0) @(negedge clk);
  endtask

  // full range, small values, extremes, or values sharing powers of two
  function automatic logic signed [IN_W-1:0] pick_operand();
    logic signed [IN_W-1:0] v;
    int unsigned            sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      v = IN_W'($urandom);
    end else if (sel < 80) begin
      v = IN_W'($urandom_range(32));
      v = v - 16'sd16;
    end else if (sel < 90) begin
      case ($urandom_range(5))
        0:       v = 16'sh8000;
        1:       v = 16'sh8001;
        2:       v = 16'shffff;
        3:       v = 16'sh0001;
        4:       v = 16'sh7fff;
        default: v = 16'sh0000;
      endcase
    end else begin
      v = IN_W'($urandom_range(255) << $urandom_range(7));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  // denominators are zero now and then, otherwise nonzero
  function automatic logic signed [IN_W-1:0] pick_denominator();
    logic signed [IN_W-1:0] v;
    if ($urandom_range(29) == 0) return '0;
    do v = pick_operand(); while (v == 0);
    return v;
  endfunction

  initial begin
    rst_n             = 1'b0;
    flush             = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    add_beats         = 0;
    mul_beats         = 0;
    zero_den_beats    = 0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_ADD;
    in_bus.first_num  = '0;
    in_bus.first_den  = '0;
    in_bus.second_num = '0;
    in_bus.second_den = '0;

    // hold reset, then release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners
    send_operands(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_operands(ACT_MUL, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_operands(ACT_ADD, 16'sh7fff, 16'sd1, 16'sh7fff, 16'sd1);
    send_operands(ACT_MUL, 16'sh7fff, 16'sd1, 16'sh7fff, 16'sd1);
    send_operands(ACT_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_operands(ACT_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_operands(ACT_ADD, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send_operands(ACT_MUL, 16'sh8000, 16'sd1, 16'sh7fff, 16'sd1);
    send_operands(ACT_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    // zero results: cancellation, zero numerator, zero over a negative denominator
    send_operands(ACT_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
    send_operands(ACT_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd3);
    send_operands(ACT_ADD, 16'sd0, -16'sd7, 16'sd0, 16'sd3);
    send_operands(ACT_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8001);
    // negative denominators carry their sign to the numerator; the last beat uses large positive values
    send_operands(ACT_ADD, 16'sd3, -16'sd4, 16'sd5, 16'sd6);
    send_operands(ACT_MUL, -16'sd3, -16'sd4, -16'sd5, -16'sd6);
    send_operands(ACT_MUL, 16'sd1, -16'sd1, 16'sd1, 16'sd1);
    send_operands(ACT_MUL, 16'sd12345, 16'sh8000, 16'sh8000, 16'sd12345);
    send_operands(ACT_ADD, 16'sh7fff, 16'sh7ffe, 16'sh7ffd, 16'sh7ffb);
    // zero denominators: first, second, both
    send_operands(ACT_ADD, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
    send_operands(ACT_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
    send_operands(ACT_ADD, -16'sd1, 16'sd0, -16'sd1, 16'sd0);
    send_operands(ACT_MUL, 16'sh7fff, 16'sd0, 16'sh8000, 16'sh8000);

    // sender holds off until the directed results are all in
    wait_results_drained();

    // random beats: no idling, sender idle, receiver stall, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      repeat (PHASE_BEATS) begin
        send_operands($urandom_range(1) ? ACT_MUL : ACT_ADD, pick_operand(),
                      pick_denominator(), pick_operand(), pick_denominator());
      end
      wait_results_drained();
    end

    // let the block settle, then flag anything left queued
    repeat (DRAIN_CYCLES) @(negedge clk);
    flush = 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("sent %0d operand beats (%0d add, %0d multiply), %0d with a zero denominator",
             add_beats + mul_beats, add_beats, mul_beats, zero_den_beats);
    $display("directed corners plus random beats over four idle/stall phases");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
